[hw/rtl/pfss_pkg.sv]
// Shared types and constants for the polyline fixed-step subdivider.
`timescale 1ns / 1ps
package pfss_pkg;

  localparam int MAX_STEPS = 32;
  localparam int KW        = $clog2(MAX_STEPS + 2);
  localparam int SW        = 31;
  localparam int TW        = SW + KW;
  localparam int DW        = 33;
  localparam int LW        = 34;
  localparam int PW        = DW + TW;
  localparam int SQW       = 2 * DW;
  localparam int RADW      = SQW;
  localparam int SREMW     = LW + 3;
  localparam int ITERS     = 33;
  localparam int IW        = 6;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_POINT = 2'd1;
  localparam logic [1:0] KIND_FINAL = 2'd2;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               last_vertex;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [1:0]         point_kind;
    logic               truncated;
    logic               last_of_run;
  } out_res_t;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       emit;
    logic [1:0] kind;
    logic       adv;
    logic       finish;
  } dp_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic last;
    logic more;
    logic more_next;
  } dp_sts_t;

endpackage

[hw/rtl/pfss_ctrl.sv]
// Controller state machine that sequences the subdivision datapath.
`timescale 1ns / 1ps
module pfss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pfss_pkg::dp_cmd_t cmd_o,
  input  pfss_pkg::dp_sts_t sts_i
);
  import pfss_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_SQI   = 4'd2;
  localparam logic [3:0] S_SQRT  = 4'd3;
  localparam logic [3:0] S_START = 4'd4;
  localparam logic [3:0] S_DIVI  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_PT    = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic          slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.have_prev ? S_MUL : S_FIN;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SQI;
      end
      S_SQI: begin
        cmd_o.sqrt_init = 1'b1;
        cnt_d           = '0;
        state_d         = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == IW'(ITERS - 1)) state_d = S_START;
      end
      S_START: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_START;
          state_d    = sts_i.more ? S_DIVI : S_FIN;
        end
      end
      S_DIVI: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == IW'(ITERS - 1)) state_d = S_PT;
      end
      S_PT: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_POINT;
          cmd_o.adv  = 1'b1;
          state_d    = sts_i.more_next ? S_DIVI : S_FIN;
        end
      end
      S_FIN: begin
        if (!sts_i.last) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else if (slot_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.kind   = KIND_FINAL;
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hw/rtl/pfss_dp.sv]
// Datapath: deltas, squares, bitwise square root, per-point long division, result register.
`timescale 1ns / 1ps
module pfss_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [30:0]       cfg_wdata_i,
  input  pfss_pkg::in_req_t in_req_i,
  input  pfss_pkg::dp_cmd_t cmd_i,
  output pfss_pkg::dp_sts_t sts_o,
  output pfss_pkg::out_res_t out_res_o
);
  import pfss_pkg::*;

  logic [SW-1:0]        step_q, step_eff;
  logic signed [31:0]   prev_x_q, prev_y_q, cur_x_q, cur_y_q;
  logic                 have_prev_q, last_q;
  logic [DW-1:0]        magx_q, magy_q;
  logic                 negx_q, negy_q;
  logic [SQW-2:0]       sqx_q, sqy_q;
  logic [DW+SW-1:0]     incx_q, incy_q;
  logic [RADW-1:0]      rad_q;
  logic [SREMW-1:0]     srem_q;
  logic [LW-1:0]        root_q;
  logic [KW-1:0]        k_q;
  logic [TW-1:0]        t_q;
  logic [PW-1:0]        px_q, py_q;
  logic [LW-1:0]        rx_q, ry_q;
  logic [DW-1:0]        nx_q, ny_q, qx_q, qy_q;
  logic                 trunc_q;
  out_res_t             out_q;

  logic signed [32:0]   dx, dy;
  logic [SREMW-1:0]     sh, trial;
  logic [TW:0]          tn;
  logic [TW-1:0]        thr;
  logic                 trunc_now, more, more_next;
  logic [LW:0]          shx, shy;
  logic [33:0]          ptx, pty;

  assign step_eff = (step_q == '0) ? SW'(1) : step_q;

  assign dx = {in_req_i.vertex_x[31], in_req_i.vertex_x} - {prev_x_q[31], prev_x_q};
  assign dy = {in_req_i.vertex_y[31], in_req_i.vertex_y} - {prev_y_q[31], prev_y_q};

  assign sh    = {srem_q[SREMW-3:0], rad_q[RADW-1:RADW-2]};
  assign trial = SREMW'({root_q, 2'b01});

  assign tn        = {1'b0, t_q} + (TW + 1)'(step_eff);
  assign more      = (k_q <= KW'(MAX_STEPS)) && (t_q < TW'(root_q));
  assign more_next = (k_q < KW'(MAX_STEPS)) && (tn < (TW + 1)'(root_q));
  assign thr       = TW'(step_eff) * TW'(MAX_STEPS + 1);
  assign trunc_now = TW'(root_q) > thr;

  assign shx = {rx_q, nx_q[DW-1]};
  assign shy = {ry_q, ny_q[DW-1]};

  // move from the start vertex by the quotient, toward the end vertex
  assign ptx = negx_q ? {{2{prev_x_q[31]}}, prev_x_q} - {1'b0, qx_q}
                      : {{2{prev_x_q[31]}}, prev_x_q} + {1'b0, qx_q};
  assign pty = negy_q ? {{2{prev_y_q[31]}}, prev_y_q} - {1'b0, qy_q}
                      : {{2{prev_y_q[31]}}, prev_y_q} + {1'b0, qy_q};

  assign sts_o.have_prev = have_prev_q;
  assign sts_o.last      = last_q;
  assign sts_o.more      = more;
  assign sts_o.more_next = more_next;
  assign out_res_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= SW'(65536);
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
    end else begin
      if (cfg_we_i) step_q <= cfg_wdata_i;
      if (cmd_i.finish) begin
        if (last_q) begin
          prev_x_q    <= '0;
          prev_y_q    <= '0;
          have_prev_q <= 1'b0;
        end else begin
          prev_x_q    <= cur_x_q;
          prev_y_q    <= cur_y_q;
          have_prev_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_x_q <= in_req_i.vertex_x;
      cur_y_q <= in_req_i.vertex_y;
      last_q  <= in_req_i.last_vertex;
      negx_q  <= dx[32];
      negy_q  <= dy[32];
      magx_q  <= dx[32] ? DW'(-dx) : DW'(dx);
      magy_q  <= dy[32] ? DW'(-dy) : DW'(dy);
    end
    if (cmd_i.mul) begin
      sqx_q  <= {{(SQW-1-DW){1'b0}}, magx_q} * {{(SQW-1-DW){1'b0}}, magx_q};
      sqy_q  <= {{(SQW-1-DW){1'b0}}, magy_q} * {{(SQW-1-DW){1'b0}}, magy_q};
      incx_q <= {{SW{1'b0}}, magx_q} * {{DW{1'b0}}, step_eff};
      incy_q <= {{SW{1'b0}}, magy_q} * {{DW{1'b0}}, step_eff};
    end
    if (cmd_i.sqrt_init) begin
      rad_q  <= RADW'(sqx_q) + RADW'(sqy_q);
      srem_q <= '0;
      root_q <= '0;
      k_q    <= KW'(1);
      t_q    <= TW'(step_eff);
      px_q   <= PW'(incx_q);
      py_q   <= PW'(incy_q);
    end
    if (cmd_i.sqrt_step) begin
      rad_q <= {rad_q[RADW-3:0], 2'b00};
      if (sh >= trial) begin
        srem_q <= sh - trial;
        root_q <= {root_q[LW-2:0], 1'b1};
      end else begin
        srem_q <= sh;
        root_q <= {root_q[LW-2:0], 1'b0};
      end
    end
    if (cmd_i.div_init) begin
      rx_q <= px_q[DW+LW-1:DW];
      ry_q <= py_q[DW+LW-1:DW];
      nx_q <= px_q[DW-1:0];
      ny_q <= py_q[DW-1:0];
      qx_q <= '0;
      qy_q <= '0;
    end
    if (cmd_i.div_step) begin
      nx_q <= {nx_q[DW-2:0], 1'b0};
      ny_q <= {ny_q[DW-2:0], 1'b0};
      if (shx >= {1'b0, root_q}) begin
        rx_q <= LW'(shx - {1'b0, root_q});
        qx_q <= {qx_q[DW-2:0], 1'b1};
      end else begin
        rx_q <= LW'(shx);
        qx_q <= {qx_q[DW-2:0], 1'b0};
      end
      if (shy >= {1'b0, root_q}) begin
        ry_q <= LW'(shy - {1'b0, root_q});
        qy_q <= {qy_q[DW-2:0], 1'b1};
      end else begin
        ry_q <= LW'(shy);
        qy_q <= {qy_q[DW-2:0], 1'b0};
      end
    end
    if (cmd_i.adv) begin
      k_q  <= k_q + 1'b1;
      t_q  <= tn[TW-1:0];
      px_q <= px_q + PW'(incx_q);
      py_q <= py_q + PW'(incy_q);
    end
    if (cmd_i.emit) begin
      out_q.point_kind <= cmd_i.kind;
      case (cmd_i.kind)
        KIND_START: begin
          out_q.out_x       <= prev_x_q;
          out_q.out_y       <= prev_y_q;
          out_q.truncated   <= trunc_now;
          out_q.last_of_run <= !last_q && !more;
          trunc_q           <= trunc_now;
        end
        KIND_POINT: begin
          out_q.out_x       <= ptx[31:0];
          out_q.out_y       <= pty[31:0];
          out_q.truncated   <= trunc_q;
          out_q.last_of_run <= !last_q && !more_next;
        end
        default: begin
          out_q.out_x       <= cur_x_q;
          out_q.out_y       <= cur_y_q;
          out_q.truncated   <= 1'b0;
          out_q.last_of_run <= 1'b1;
        end
      endcase
    end
  end

endmodule

[hw/rtl/polyline_fixed_step_subdivide.sv]
// Top level of the polyline fixed-step subdivider.
`timescale 1ns / 1ps
// Vertices arrive one request at a time; the block keeps the previous vertex and, per
// segment, emits the start vertex, then points spaced step_size apart along the segment
// (at most MAX_STEPS, with truncated set when more were needed), and the vertex itself
// when last_vertex is set. Before a segment's start vertex the block loads the vertex,
// forms the squares and runs a 33-step bit-serial square root; each inserted point then
// takes a 33-step long division of both axes, and a closing step also emits the final
// vertex. Results wait in a single output register, so a stalled consumer only holds the
// block when the next result is ready to go out.
module polyline_fixed_step_subdivide (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pfss_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pfss_pkg::out_res_t out_res_o,
  input  logic               cfg_we_i,
  input  logic [30:0]        cfg_wdata_i
);
  import pfss_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  pfss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pfss_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_res_o   (out_res_o)
  );

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while previous one in flight");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_res_o.point_kind == KIND_START || out_res_o.point_kind == KIND_POINT
                     || out_res_o.point_kind == KIND_FINAL))
    else $error("illegal point kind");

  a_final_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.point_kind == KIND_FINAL |->
      out_res_o.last_of_run && !out_res_o.truncated)
    else $error("final vertex flags wrong");

  a_no_emit_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_res_o))
    else $error("result overwritten while stalled");
`endif

endmodule
